>>> sv/rspt_pkg.sv
// rspt_pkg: shared constants, types and the sine table builder for the rotating sector
// point test; used by rspt_sine_rom and rotating_sector_point_test
// depends on nothing
package rspt_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned COORD_WIDTH      = 16;

  localparam int unsigned AngW        = 16;
  localparam int unsigned ReachW      = 14;
  localparam int unsigned FullTurn    = 36000;
  localparam int unsigned QuarterTurn = 9000;

  localparam int unsigned CornerW  = COORD_WIDTH + 1;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = (COORD_WIDTH > AngW) ? COORD_WIDTH : AngW;
  localparam int unsigned InDataW  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 1 + 4 * CornerW + AngW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // sine table
  localparam int unsigned SineW    = 17;
  localparam int unsigned SineFrac = 15;
  localparam int unsigned IdxW     = $clog2(SINE_TABLE_DEPTH);
  localparam longint unsigned HalfPiQ60 = 64'h1921FB54442D1846;

  // series term divisors (2i)(2i+1) as reciprocals rounded up, i = 8 down to 1
  localparam int unsigned TermShift = 48;
  localparam logic [7:0][63:0] TermRecip = {
    ((64'd1 << TermShift) + 64'd271) / 64'd272,
    ((64'd1 << TermShift) + 64'd209) / 64'd210,
    ((64'd1 << TermShift) + 64'd155) / 64'd156,
    ((64'd1 << TermShift) + 64'd109) / 64'd110,
    ((64'd1 << TermShift) + 64'd71) / 64'd72,
    ((64'd1 << TermShift) + 64'd41) / 64'd42,
    ((64'd1 << TermShift) + 64'd19) / 64'd20,
    ((64'd1 << TermShift) + 64'd5) / 64'd6
  };

  // angle to table index by reciprocal multiply and one correction
  localparam int unsigned RecipShift = 25;
  localparam longint unsigned IdxRecip =
    ((64'd1 << RecipShift) * SINE_TABLE_DEPTH) / FullTurn;
  localparam int unsigned IdxRecipW = $clog2(IdxRecip + 1);
  localparam int unsigned EstW      = AngW + IdxRecipW;
  localparam int unsigned CmpW      = AngW + IdxW + 1;

  // corner arithmetic
  localparam int unsigned MulW  = ReachW + 1 + SineW;
  localparam int unsigned DispW = ReachW + 1;
  localparam int unsigned SumW  = ((COORD_WIDTH > DispW) ? COORD_WIDTH : DispW) + 1;
  localparam int unsigned DiffW = SumW + 1;
  localparam int unsigned PW    = 2 * DiffW;
  localparam int unsigned AbsW  = PW + 1;
  localparam int unsigned PartsW = AbsW + 2;

  // whole area is at most 2 * reach^2, quotient by 200 is exact with this reciprocal
  localparam int unsigned WholeW     = 2 * ReachW + 2;
  localparam int unsigned AreaDiv    = 200;
  localparam int unsigned AreaShift  = WholeW + 8;
  localparam longint unsigned AreaRecip =
    ((64'd1 << AreaShift) + AreaDiv - 1) / AreaDiv;
  localparam int unsigned AreaRecipW = $clog2(AreaRecip + 1);
  localparam int unsigned QMulW      = WholeW + AreaRecipW;
  localparam int unsigned QW         = WholeW - 7;

  typedef enum logic {
    CmdTick  = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegOriginX     = 3'd0,
    RegOriginY     = 3'd1,
    RegReach       = 3'd2,
    RegSectorWidth = 3'd3,
    RegAngleStep   = 3'd4
  } cfg_reg_e;

  typedef logic [SINE_TABLE_DEPTH-1:0][SineW-1:0] sine_tab_t;

  // q30 taylor series to x^17, rounded half up to q15
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint unsigned d;
    longint unsigned a;
    longint unsigned r;
    longint unsigned x60;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned v;
    logic [127:0]    prod;
    logic neg;
    d = 64'(SINE_TABLE_DEPTH);
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      a   = 64'(4 * k);
      neg = 1'b0;
      if (a < d) begin
        r = a;
      end else if (a < 2 * d) begin
        r = 2 * d - a;
      end else if (a < 3 * d) begin
        r   = a - 2 * d;
        neg = 1'b1;
      end else begin
        r   = 4 * d - a;
        neg = 1'b1;
      end
      x60  = (HalfPiQ60 / SINE_TABLE_DEPTH) * r
           + ((HalfPiQ60 % SINE_TABLE_DEPTH) * r) / SINE_TABLE_DEPTH;
      x    = x60 >> 30;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int i = 1; i <= 8; i++) begin
        prod = 128'((term * x2) >> 30) * 128'(TermRecip[i - 1]);
        term = 64'(prod >> TermShift);
        if ((i & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 64'd16384) >> 15;
      tab[k] = neg ? SineW'(64'd0 - v) : SineW'(v);
    end
    return tab;
  endfunction

endpackage

>>> sv/rspt_sine_rom.sv
// rspt_sine_rom: dual read port sine rom with registered read data
// depends on rspt_pkg for table depth, entry width and the table builder
module rspt_sine_rom (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic        [rspt_pkg::IdxW-1:0]     addr_a_i,
  input  logic        [rspt_pkg::IdxW-1:0]     addr_b_i,
  output logic signed [rspt_pkg::SineW-1:0]    data_a_o,
  output logic signed [rspt_pkg::SineW-1:0]    data_b_o
);
  import rspt_pkg::*;

  localparam sine_tab_t SineTab = build_sine_tab();

  logic signed [SineW-1:0] data_a_q;
  logic signed [SineW-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= $signed(SineTab[addr_a_i]);
      data_b_q <= $signed(SineTab[addr_b_i]);
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

>>> sv/rotating_sector_point_test.sv
// rotating_sector_point_test: rotating triangular sector with point containment test
// depends on rspt_pkg and rspt_sine_rom
// throughput: one request per cycle unless the output stalls; a ten stage pipeline with
//   per stage stall, the four corner lookups share two dual port sine roms read once
//   per request
// reset: configuration registers, azimuth and all stage valids clear at once;
//   the sine table is constant and needs no fill
module rotating_sector_point_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rspt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rspt_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // point_x, point_y
  input  logic [rspt_pkg::InDataW-1:0]      s_axis_tdata_i,
  // command
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // inside_res, corner1_x, corner1_y, corner2_x, corner2_y, heading, zero pad
  output logic [rspt_pkg::OutDataW-1:0]     m_axis_tdata_o
);
  import rspt_pkg::*;

  localparam int unsigned NSt = 10;
  localparam logic [AngW:0] Turn1 = (AngW + 1)'(FullTurn);
  localparam logic [AngW:0] Turn2 = (AngW + 1)'(2 * FullTurn);
  localparam logic [AngW:0] Turn3 = (AngW + 1)'(3 * FullTurn);
  localparam logic [AngW:0] Quart = (AngW + 1)'(QuarterTurn);
  localparam logic signed [MulW-1:0] RoundHalf = MulW'(1 << (SineFrac - 1));

  // configuration
  logic signed [COORD_WIDTH-1:0] origin_x_q, origin_y_q;
  logic [ReachW-1:0]             reach_q;
  logic [AngW-1:0]               sector_width_q, angle_step_q;
  logic [AngW-1:0]               azimuth_q, azimuth_d;

  // pipeline control
  logic [NSt:1] v_q;
  logic [NSt:1] en;
  logic         accept;

  // carried fields
  cmd_e                          cmd_q [1:9];
  logic [AngW-1:0]               az_q  [1:9];
  logic signed [COORD_WIDTH-1:0] px_q  [1:6];
  logic signed [COORD_WIDTH-1:0] py_q  [1:6];
  logic signed [SumW-1:0]        cor_q [7:9][4];

  // stage payloads
  logic [AngW-1:0]          ang_d [4], ang_q [4], ang3_q [4];
  logic [EstW-1:0]          est_prod [4];
  logic [IdxW-1:0]          est_q [4], addr [4];
  logic [CmpW-1:0]          cmp_lhs [4], cmp_rhs [4];
  logic signed [SineW-1:0]  sin [4];
  logic signed [MulW-1:0]   prod5_q [4], rnd [4];
  logic signed [DispW-1:0]  disp_d [4], dsp6_q [4];
  logic signed [SumW-1:0]   crn_d [4], crn6_q [4];
  logic signed [DiffW-1:0]  fa [8], fb [8];
  logic signed [PW-1:0]     mul_q [8];
  logic signed [AbsW-1:0]   dif [4];
  logic [AbsW-1:0]          mag [4];
  logic [WholeW-1:0]        whole8_q;
  logic [AbsW-1:0]          tri8_q [3];
  logic [PartsW-1:0]        parts9_q;
  logic [QMulW-1:0]         qmul;
  logic [QW-1:0]            q9_q;
  logic [AngW:0]            tick_sum, a1c_s, a2_s, a2c_s, a2_m, a2c_m, a1c_m;
  logic                     hit;
  logic [OutDataW-1:0]      out_tdata_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      reach_q        <= '0;
      sector_width_q <= '0;
      angle_step_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegOriginX:     origin_x_q     <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        RegOriginY:     origin_y_q     <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        RegReach:       reach_q        <= cfg_data_i[ReachW-1:0];
        RegSectorWidth: sector_width_q <= cfg_data_i[AngW-1:0];
        RegAngleStep:   angle_step_q   <= cfg_data_i[AngW-1:0];
        default: ;
      endcase
    end
  end

  // stall chain: a stage takes new data when empty or when it moves on
  always_comb begin
    en[NSt] = !v_q[NSt] || m_axis_tready_i;
    for (int k = NSt - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k + 1];
    end
  end

  assign s_axis_tready_o = en[1];
  assign accept          = s_axis_tvalid_i && en[1];

  // azimuth update on tick
  always_comb begin
    tick_sum  = {1'b0, azimuth_q} + {1'b0, angle_step_q};
    azimuth_d = azimuth_q;
    if (cmd_e'(s_axis_tuser_i) == CmdTick) begin
      azimuth_d = (tick_sum >= Turn1) ? '0 : tick_sum[AngW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      azimuth_q <= '0;
      v_q       <= '0;
    end else begin
      if (accept) begin
        azimuth_q <= azimuth_d;
      end
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= NSt; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k - 1];
        end
      end
    end
  end

  // carried fields
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cmd_q[1] <= cmd_e'(s_axis_tuser_i);
      az_q[1]  <= azimuth_d;
      px_q[1]  <= $signed(s_axis_tdata_i[COORD_WIDTH-1:0]);
      py_q[1]  <= $signed(s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH]);
    end
    for (int k = 2; k <= 9; k++) begin
      if (en[k]) begin
        cmd_q[k] <= cmd_q[k - 1];
        az_q[k]  <= az_q[k - 1];
      end
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        px_q[k] <= px_q[k - 1];
        py_q[k] <= py_q[k - 1];
      end
    end
    if (en[7]) begin
      cor_q[7] <= crn6_q;
    end
    for (int k = 8; k <= 9; k++) begin
      if (en[k]) begin
        cor_q[k] <= cor_q[k - 1];
      end
    end
  end

  // stage 2: corner angles, cosine as sine of angle plus a quarter turn
  always_comb begin
    a1c_s = {1'b0, az_q[1]} + Quart;
    a1c_m = (a1c_s >= Turn1) ? a1c_s - Turn1 : a1c_s;
    a2_s  = {1'b0, az_q[1]} + {1'b0, sector_width_q};
    if (a2_s >= Turn2) begin
      a2_m = a2_s - Turn2;
    end else if (a2_s >= Turn1) begin
      a2_m = a2_s - Turn1;
    end else begin
      a2_m = a2_s;
    end
    a2c_s = a2_s + Quart;
    if (a2c_s >= Turn3) begin
      a2c_m = a2c_s - Turn3;
    end else if (a2c_s >= Turn2) begin
      a2c_m = a2c_s - Turn2;
    end else if (a2c_s >= Turn1) begin
      a2c_m = a2c_s - Turn1;
    end else begin
      a2c_m = a2c_s;
    end
    ang_d[0] = a1c_m[AngW-1:0];
    ang_d[1] = az_q[1];
    ang_d[2] = a2c_m[AngW-1:0];
    ang_d[3] = a2_m[AngW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ang_q <= ang_d;
    end
  end

  // stage 3: index estimate; corrected index addresses the roms
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      est_prod[i] = EstW'(ang_q[i]) * EstW'(IdxRecip);
      cmp_lhs[i]  = CmpW'(ang3_q[i]) * CmpW'(SINE_TABLE_DEPTH);
      cmp_rhs[i]  = (CmpW'(est_q[i]) + CmpW'(1)) * CmpW'(FullTurn);
      addr[i]     = (cmp_lhs[i] >= cmp_rhs[i]) ? est_q[i] + IdxW'(1) : est_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        est_q[i] <= est_prod[i][RecipShift +: IdxW];
      end
      ang3_q <= ang_q;
    end
  end

  // stage 4: rom read
  rspt_sine_rom u_rom_c1 (
    .clk_i    (clk_i),
    .en_i     (en[4]),
    .addr_a_i (addr[0]),
    .addr_b_i (addr[1]),
    .data_a_o (sin[0]),
    .data_b_o (sin[1])
  );

  rspt_sine_rom u_rom_c2 (
    .clk_i    (clk_i),
    .en_i     (en[4]),
    .addr_a_i (addr[2]),
    .addr_b_i (addr[3]),
    .data_a_o (sin[2]),
    .data_b_o (sin[3])
  );

  // stage 5: scale by reach
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int i = 0; i < 4; i++) begin
        prod5_q[i] <= MulW'($signed({1'b0, reach_q})) * MulW'(sin[i]);
      end
    end
  end

  // stage 6: round to cm and offset by origin
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i]    = prod5_q[i] + RoundHalf;
      disp_d[i] = $signed(rnd[i][SineFrac +: DispW]);
      if ((i & 1) == 0) begin
        crn_d[i] = SumW'(origin_x_q) + SumW'(disp_d[i]);
      end else begin
        crn_d[i] = SumW'(origin_y_q) + SumW'(disp_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      dsp6_q <= disp_d;
      crn6_q <= crn_d;
    end
  end

  // stage 7: cross products of whole triangle and the three sub-triangles
  always_comb begin
    fa[0] = DiffW'(dsp6_q[0]);
    fb[0] = DiffW'(dsp6_q[3]);
    fa[1] = DiffW'(dsp6_q[1]);
    fb[1] = DiffW'(dsp6_q[2]);
    fa[2] = DiffW'(dsp6_q[0]);
    fb[2] = DiffW'(py_q[6]) - DiffW'(origin_y_q);
    fa[3] = DiffW'(dsp6_q[1]);
    fb[3] = DiffW'(px_q[6]) - DiffW'(origin_x_q);
    fa[4] = DiffW'(dsp6_q[2]);
    fb[4] = DiffW'(py_q[6]) - DiffW'(origin_y_q);
    fa[5] = DiffW'(dsp6_q[3]);
    fb[5] = DiffW'(px_q[6]) - DiffW'(origin_x_q);
    fa[6] = DiffW'(crn6_q[2]) - DiffW'(crn6_q[0]);
    fb[6] = DiffW'(py_q[6]) - DiffW'(crn6_q[1]);
    fa[7] = DiffW'(crn6_q[3]) - DiffW'(crn6_q[1]);
    fb[7] = DiffW'(px_q[6]) - DiffW'(crn6_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int j = 0; j < 8; j++) begin
        mul_q[j] <= PW'(fa[j]) * PW'(fb[j]);
      end
    end
  end

  // stage 8: doubled areas
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dif[j] = AbsW'(mul_q[2 * j]) - AbsW'(mul_q[2 * j + 1]);
      mag[j] = dif[j][AbsW-1] ? AbsW'(-dif[j]) : AbsW'(dif[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      whole8_q  <= mag[0][WholeW-1:0];
      tri8_q[0] <= mag[1];
      tri8_q[1] <= mag[2];
      tri8_q[2] <= mag[3];
    end
  end

  // stage 9: sum of parts and whole area over 200
  assign qmul = QMulW'(whole8_q) * QMulW'(AreaRecip);

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      parts9_q <= PartsW'(tri8_q[0]) + PartsW'(tri8_q[1]) + PartsW'(tri8_q[2]);
      q9_q     <= qmul[AreaShift +: QW];
    end
  end

  // stage 10: parts never fall below the whole, so equal quotients mean
  // parts below the next multiple of 200
  assign hit = (cmd_q[9] == CmdQuery)
            && (parts9_q < (PartsW'(q9_q) + PartsW'(1)) * PartsW'(AreaDiv));

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      out_tdata_q <= OutDataW'({az_q[9],
                                cor_q[9][3][CornerW-1:0],
                                cor_q[9][2][CornerW-1:0],
                                cor_q[9][1][CornerW-1:0],
                                cor_q[9][0][CornerW-1:0],
                                hit});
    end
  end

  assign m_axis_tvalid_o = v_q[NSt];
  assign m_axis_tdata_o  = out_tdata_q;

endmodule
